// File: design/hbe_pkg.sv
// shared types and constants for the heightmap brush engine
`timescale 1ns / 1ps
package hbe_pkg;
  localparam int MaxWidth   = 512;
  localparam int MaxHeight  = 512;
  localparam int MaxRadius  = 31;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int PixW       = 24;
  localparam int StepAmount = 5;
  localparam int ChanTop    = 255;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_MOVE   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_PIC_W  = 3'd0,
    REG_PIC_H  = 3'd1,
    REG_PANE_W = 3'd2,
    REG_PANE_H = 3'd3,
    REG_RADIUS = 3'd4
  } reg_t;

  // buttons of a button event
  typedef enum logic [1:0] {
    BTN_LEFT   = 2'd0,
    BTN_RIGHT  = 2'd1,
    BTN_MIDDLE = 2'd2
  } btn_t;

  // brush modes of one walk over the square
  typedef enum logic [1:0] {
    MODE_BRIGHT = 2'd0,
    MODE_DARK   = 2'd1,
    MODE_FLAT   = 2'd2,
    MODE_SUM    = 2'd3
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic  btn_set;    // update the button flags
    logic  map_start;  // start coordinate mapping
    logic  walk_start; // start a square walk
    mode_t mode;
    logic  div_start;  // start area division
    logic  host_wr;    // host pixel write
    logic  host_rd;    // host pixel read issue
    logic  rd_done;    // present read data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic map_done;
    logic map_valid;
    logic walk_done;
    logic div_done;
  } stat_t;
endpackage

// File: design/hbe_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module hbe_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/hbe_datapath.sv
// datapath: config registers, mapping, square walker, divider, picture store
`timescale 1ns / 1ps
module hbe_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hbe_pkg::cmd_t      cmd,
  output hbe_pkg::stat_t     stat,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic [1:0]         button,
  input  logic               pressed,
  input  logic [11:0]        pointer_x,
  input  logic [11:0]        pointer_y,
  input  logic [17:0]        pixel_index,
  input  logic [23:0]        pixel_value,
  output logic               left_held,
  output logic               right_held,
  output logic               middle_held,
  output logic [23:0]        read_value
);
  localparam int AW = hbe_pkg::AddrW;

  logic [9:0]  pic_w, pic_h;
  logic [11:0] pane_w, pane_h;
  logic [4:0]  radius;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pic_w  <= 10'd512;
      pic_h  <= 10'd512;
      pane_w <= 12'd512;
      pane_h <= 12'd512;
      radius <= 5'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hbe_pkg::REG_PIC_W:  pic_w  <= cfg_data[9:0];
        hbe_pkg::REG_PIC_H:  pic_h  <= cfg_data[9:0];
        hbe_pkg::REG_PANE_W: pane_w <= cfg_data;
        hbe_pkg::REG_PANE_H: pane_h <= cfg_data;
        hbe_pkg::REG_RADIUS: radius <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [9:0] eff_w, eff_h;
  logic [4:0] eff_r;
  always_comb begin
    eff_w = (pic_w > 10'(hbe_pkg::MaxWidth)) ? 10'(hbe_pkg::MaxWidth) : pic_w;
    eff_h = (pic_h > 10'(hbe_pkg::MaxHeight)) ? 10'(hbe_pkg::MaxHeight) : pic_h;
    eff_r = (radius > 5'(hbe_pkg::MaxRadius)) ? 5'(hbe_pkg::MaxRadius) : radius;
  end

  // item capture at the accepting edge
  logic [1:0]  btn_q;
  logic        prs_q;
  logic [11:0] x_q, y_q;
  logic [17:0] idx_q;
  logic [23:0] val_q;
  always_ff @(posedge clk) begin
    if (load) begin
      btn_q <= button;
      prs_q <= pressed;
      x_q   <= pointer_x;
      y_q   <= pointer_y;
      idx_q <= pixel_index;
      val_q <= pixel_value;
    end
  end

  // button flags
  always_ff @(posedge clk) begin
    if (rst) begin
      left_held   <= 1'b0;
      right_held  <= 1'b0;
      middle_held <= 1'b0;
    end else if (cmd.btn_set) begin
      case (btn_q)
        hbe_pkg::BTN_LEFT:   left_held   <= prs_q;
        hbe_pkg::BTN_RIGHT:  right_held  <= prs_q;
        hbe_pkg::BTN_MIDDLE: middle_held <= prs_q;
        default: ;
      endcase
    end
  end

  // shared restoring divider: one quotient bit a cycle
  logic [21:0] dv_num, dv_q;
  logic [11:0] dv_den;
  logic [12:0] dv_rem;
  logic [4:0]  dv_cnt;
  logic        dv_busy;
  logic [12:0] dv_trial;
  logic [13:0] dv_sub;
  always_comb begin
    dv_trial = {dv_rem[11:0], dv_num[21]};
    dv_sub   = {1'b0, dv_trial} - {2'b0, dv_den};
  end

  // mapping sequencer
  typedef enum logic [2:0] {M_IDLE, M_MULX, M_DIVX, M_MULY, M_DIVY, M_FIN} mstate_t;
  mstate_t     mst;
  logic [9:0]  px;
  logic [10:0] py;      // signed-free: stored as h - q, may be 0..h
  logic        dv_go;
  logic [21:0] dv_in_num;
  logic [11:0] dv_in_den;
  logic        map_valid;

  // walker and divisor results
  logic [19:0] area_sum;
  logic [7:0]  flat_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (dv_go) begin
      dv_busy <= 1'b1;
      dv_num  <= dv_in_num;
      dv_den  <= dv_in_den;
      dv_rem  <= '0;
      dv_q    <= '0;
      dv_cnt  <= 5'd22;
    end else if (dv_busy) begin
      dv_num <= {dv_num[20:0], 1'b0};
      if (!dv_sub[13]) begin
        dv_rem <= dv_sub[12:0];
        dv_q   <= {dv_q[20:0], 1'b1};
      end else begin
        dv_rem <= dv_trial;
        dv_q   <= {dv_q[20:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 5'd1;
      if (dv_cnt == 5'd1) begin
        dv_busy <= 1'b0;
      end
    end
  end

  logic dv_fin;
  assign dv_fin = dv_busy && (dv_cnt == 5'd1);
  logic [21:0] dv_res;
  assign dv_res = dv_sub[13] ? {dv_q[20:0], 1'b0} : {dv_q[20:0], 1'b1};

  logic [21:0] prod;
  logic        map_done;
  logic        div_done;
  logic        dsel;   // 1 while divider works on the area
  logic [5:0]  side;
  logic [11:0] area;
  always_comb begin
    side = {eff_r, 1'b1};
    area = 12'(side * side);
  end

  always_comb begin
    dv_go     = 1'b0;
    dv_in_num = prod;
    dv_in_den = pane_w;
    if (mst == M_MULX) begin
      dv_go = 1'b1;
    end else if (mst == M_MULY) begin
      dv_go     = 1'b1;
      dv_in_num = prod + 22'(pane_h) - 22'd1;
      dv_in_den = pane_h;
    end else if (cmd.div_start) begin
      dv_go     = 1'b1;
      dv_in_num = 22'(area_sum);
      dv_in_den = area;
    end
  end

  // mapping state machine; also flags the end of the area division
  always_ff @(posedge clk) begin
    if (rst) begin
      mst       <= M_IDLE;
      map_done  <= 1'b0;
      div_done  <= 1'b0;
      dsel      <= 1'b0;
      map_valid <= 1'b0;
    end else begin
      map_done <= 1'b0;
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dsel <= 1'b1;
      end
      if (dsel && dv_fin) begin
        dsel     <= 1'b0;
        div_done <= 1'b1;
        flat_val <= dv_res[7:0];
      end
      unique case (mst)
        M_IDLE: begin
          if (cmd.map_start) begin
            prod <= 22'(x_q * eff_w);
            mst  <= M_MULX;
            map_valid <= (x_q < pane_w) && (y_q < pane_h);
          end
        end
        M_MULX: mst <= M_DIVX;
        M_DIVX: begin
          if (dv_fin) begin
            px   <= dv_res[9:0];
            prod <= 22'(y_q * eff_h);
            mst  <= M_MULY;
          end
        end
        M_MULY: mst <= M_DIVY;
        M_DIVY: begin
          if (dv_fin) begin
            py  <= 11'(eff_h) - dv_res[10:0];
            mst <= M_FIN;
          end
        end
        M_FIN: begin
          map_done <= 1'b1;
          mst      <= M_IDLE;
        end
        default: mst <= M_IDLE;
      endcase
    end
  end

  // square walker: read, then write back, per pixel (sum mode reads only)
  typedef enum logic [1:0] {W_IDLE, W_ADDR, W_READ, W_WRITE} wstate_t;
  wstate_t     wst;
  logic signed [12:0] row, col, row_end, col_end, col_start;
  logic [1:0]  wmode;
  logic        walk_done;
  logic [AW-1:0] waddr;
  logic        in_pic;
  logic [23:0] ram_rd;
  logic [23:0] wnew;
  logic [18:0] lin;

  always_comb begin
    in_pic = (row >= 0) && (row < $signed({3'b0, eff_h})) &&
             (col >= 0) && (col < $signed({3'b0, eff_w}));
  end

  function automatic logic [7:0] chan(input logic [7:0] v, input logic [1:0] m,
                                      input logic [7:0] f);
    logic [8:0] s;
    s = {1'b0, v} + 9'(hbe_pkg::StepAmount);
    case (m)
      hbe_pkg::MODE_BRIGHT: chan = (s > 9'(hbe_pkg::ChanTop)) ? 8'(hbe_pkg::ChanTop) : s[7:0];
      hbe_pkg::MODE_DARK:   chan = (v > 8'(hbe_pkg::StepAmount)) ?
                                   v - 8'(hbe_pkg::StepAmount) : 8'd0;
      default:              chan = f;
    endcase
  endfunction

  always_comb begin
    wnew = {chan(ram_rd[23:16], wmode, flat_val), chan(ram_rd[15:8], wmode, flat_val),
            chan(ram_rd[7:0], wmode, flat_val)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wst       <= W_IDLE;
      walk_done <= 1'b0;
    end else begin
      walk_done <= 1'b0;
      unique case (wst)
        W_IDLE: begin
          if (cmd.walk_start) begin
            wmode     <= cmd.mode;
            row       <= $signed({3'b0, py[9:0]}) - $signed({8'b0, eff_r});
            col_start <= $signed({3'b0, px}) - $signed({8'b0, eff_r});
            col       <= $signed({3'b0, px}) - $signed({8'b0, eff_r});
            row_end   <= $signed({2'b0, py}) + $signed({8'b0, eff_r});
            col_end   <= $signed({3'b0, px}) + $signed({8'b0, eff_r});
            area_sum  <= '0;
            wst       <= W_ADDR;
          end
        end
        W_ADDR: begin
          if (in_pic) begin
            lin   <= 19'(row[9:0] * eff_w) + 19'(col[9:0]);
            wst   <= W_READ;
          end else begin
            if (col == col_end) begin
              col <= col_start;
              row <= row + 13'sd1;
              if (row == row_end) begin
                wst       <= W_IDLE;
                walk_done <= 1'b1;
              end
            end else begin
              col <= col + 13'sd1;
            end
          end
        end
        W_READ: wst <= W_WRITE;
        W_WRITE: begin
          if (wmode == hbe_pkg::MODE_SUM) begin
            area_sum <= area_sum + 20'(ram_rd[7:0]);
          end
          if (col == col_end) begin
            col <= col_start;
            row <= row + 13'sd1;
            if (row == row_end) begin
              wst       <= W_IDLE;
              walk_done <= 1'b1;
            end else begin
              wst <= W_ADDR;
            end
          end else begin
            col <= col + 13'sd1;
            wst <= W_ADDR;
          end
        end
        default: wst <= W_IDLE;
      endcase
    end
  end

  // store port: walker or host
  logic ram_we;
  logic [23:0] ram_wd;
  logic idx_ok;
  assign idx_ok = ({1'b0, idx_q} < 19'(hbe_pkg::StoreDepth));
  always_comb begin
    ram_we = 1'b0;
    ram_wd = wnew;
    waddr  = AW'(lin);
    if (wst == W_WRITE) begin
      ram_we = (wmode != hbe_pkg::MODE_SUM);
    end else if (cmd.host_wr || cmd.host_rd) begin
      waddr  = AW'(idx_q);
      ram_we = cmd.host_wr && idx_ok;
      ram_wd = val_q;
    end
  end

  hbe_ram #(.Width(hbe_pkg::PixW), .Depth(hbe_pkg::StoreDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (waddr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  // result word
  always_ff @(posedge clk) begin
    if (load) begin
      read_value <= '0;
    end else if (cmd.rd_done && idx_ok) begin
      read_value <= ram_rd;
    end
  end

  assign stat.map_done  = map_done;
  assign stat.map_valid = map_valid;
  assign stat.walk_done = walk_done;
  assign stat.div_done  = div_done;
endmodule

// File: design/hbe_ctrl.sv
// controller: sequences one item through the datapath
`timescale 1ns / 1ps
module hbe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     operation,
  input  logic           left_held,
  input  logic           right_held,
  input  logic           middle_held,
  input  hbe_pkg::stat_t stat,
  output hbe_pkg::cmd_t  cmd,
  output logic           load,
  output logic           busy,
  output logic           done
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MAP, S_LEFT, S_RIGHT, S_SUM, S_DIV, S_FLAT,
    S_RD1, S_RD2, S_FIN
  } state_t;
  state_t st;
  logic [1:0] op_q;
  logic       issued;

  // item fields are captured at the accepting edge
  assign load = (st == S_IDLE) && start && !busy;

  // state and registered commands
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      cmd    <= '0;
      busy   <= 1'b0;
      done   <= 1'b0;
      issued <= 1'b0;
      op_q   <= '0;
    end else begin
      cmd  <= '0;
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start && !busy) begin
            busy     <= 1'b1;
            op_q     <= operation;
            st       <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op_q)
            hbe_pkg::OP_BUTTON: begin
              cmd.btn_set <= 1'b1;
              st <= S_FIN;
            end
            hbe_pkg::OP_MOVE: begin
              cmd.map_start <= 1'b1;
              st <= S_MAP;
            end
            hbe_pkg::OP_WRITE: begin
              cmd.host_wr <= 1'b1;
              st <= S_FIN;
            end
            hbe_pkg::OP_READ: begin
              cmd.host_rd <= 1'b1;
              st <= S_RD1;
            end
            default: st <= S_FIN;
          endcase
          issued <= 1'b0;
        end
        S_MAP: begin
          if (stat.map_done) begin
            st <= !stat.map_valid ? S_FIN : S_LEFT;
          end
        end
        S_LEFT, S_RIGHT, S_SUM, S_FLAT: begin
          if (!issued) begin
            if ((st == S_LEFT && !left_held) || (st == S_RIGHT && !right_held) ||
                ((st == S_SUM || st == S_FLAT) && !middle_held)) begin
              st <= (st == S_LEFT) ? S_RIGHT : (st == S_RIGHT) ? S_SUM : S_FIN;
            end else begin
              issued         <= 1'b1;
              cmd.walk_start <= 1'b1;
              cmd.mode       <= (st == S_LEFT)  ? hbe_pkg::MODE_BRIGHT :
                                (st == S_RIGHT) ? hbe_pkg::MODE_DARK :
                                (st == S_SUM)   ? hbe_pkg::MODE_SUM : hbe_pkg::MODE_FLAT;
            end
          end else if (stat.walk_done) begin
            issued <= 1'b0;
            if (st == S_SUM) begin
              cmd.div_start <= 1'b1;
              st <= S_DIV;
            end else begin
              st <= (st == S_LEFT) ? S_RIGHT : (st == S_RIGHT) ? S_SUM : S_FIN;
            end
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            st <= S_FLAT;
          end
        end
        S_RD1: begin
          cmd.rd_done <= 1'b1;
          st <= S_RD2;
        end
        S_RD2: st <= S_FIN;
        S_FIN: begin
          if (!cmd.rd_done) begin
            done <= 1'b1;
            busy <= 1'b0;
            st   <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/heightmap_brush_engine_core.sv
// top level of the heightmap brush engine
`timescale 1ns / 1ps
// usage:
// - raise start with operation and its fields while busy is low; the word is
//   taken at that edge and busy rises for the whole item
// - done strobes for one cycle with read_value (pixel for in-range reads, zero else);
//   the receiver cannot stall, so the word must be taken in that cycle
// - button and pixel write items go from S_DECODE to S_FIN, reads pass
//   S_RD1 and S_RD2 on the way; busy falls with done, so the next word
//   can be taken at the edge that ends the done cycle
// - a move runs coordinate mapping (two 22-step serial divisions), then one
//   walk over the (2r+1)^2 square per held button; an in-picture pixel passes
//   W_ADDR, W_READ and W_WRITE, an outside pixel only W_ADDR; flatten walks
//   twice with an area division between, so up to four walks of 3969 pixels
// - the single-port picture memory sets the walk rate: read, then write back
// - configuration words (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
//   only while no item is in flight
// - synchronous reset clears flags, sets registers to defaults; the picture
//   memory is not cleared and reads back undefined until written
module heightmap_brush_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  operation,
  input  logic [1:0]  button,
  input  logic        pressed,
  input  logic [11:0] pointer_x,
  input  logic [11:0] pointer_y,
  input  logic [17:0] pixel_index,
  input  logic [23:0] pixel_value,
  output logic [23:0] read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  hbe_pkg::cmd_t  cmd;
  hbe_pkg::stat_t stat;
  logic lh, rh, mh;
  logic load;

  assign cfg_ready = !busy;

  hbe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .left_held(lh), .right_held(rh), .middle_held(mh),
    .stat(stat), .cmd(cmd), .load(load), .busy(busy), .done(done)
  );

  hbe_datapath u_dp (
    .clk(clk), .rst(rst), .load(load), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .button(button), .pressed(pressed), .pointer_x(pointer_x), .pointer_y(pointer_y),
    .pixel_index(pixel_index), .pixel_value(pixel_value),
    .left_held(lh), .right_held(rh), .middle_held(mh), .read_value(read_value)
  );
endmodule
